// ===== hw/rtl/dflp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dflp_pkg
// Shared types, codes and constants of the decimal field list parser.
// ----------------------------------------------------------------------------
package dflp_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_FIELD_COUNT  = 2'd0;
  localparam logic [1:0] CFG_WIDE_MODE    = 2'd1;
  localparam logic [1:0] CFG_NONZERO_LEAD = 2'd2;

  // Result kinds
  localparam logic KIND_FIELD  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Final status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_CHAR   = 3'd1,
    ST_OVERFLOW   = 3'd2,
    ST_TOO_FEW    = 3'd3,
    ST_TRAILING   = 3'd4,
    ST_ZERO_COUNT = 3'd5
  } status_t;

  // Characters
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  // Largest accumulator that still accepts another digit: (limit - d) / 10
  localparam logic [63:0] LIM32_LO = 64'd429496729;
  localparam logic [63:0] LIM32_HI = 64'd429496728;
  localparam logic [63:0] LIM64_LO = 64'd1844674407370955161;
  localparam logic [63:0] LIM64_HI = 64'd1844674407370955160;
  localparam logic [3:0]  DIGIT_SPLIT = 4'd5;

  // Queue depth for results
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0] field_count;
    logic       wide_mode;
    logic       require_nonzero_lead;
  } cfg_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  field_number;
    logic [63:0] field_value;
    status_t     parse_status;
    logic        last_item;
  } result_t;

  // Up to two results from one character
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic [63:0] digit_limit(input logic wide, input logic [3:0] d);
    if (wide) begin
      return (d <= DIGIT_SPLIT) ? LIM64_LO : LIM64_HI;
    end
    return (d <= DIGIT_SPLIT) ? LIM32_LO : LIM32_HI;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/decimal_field_list_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_field_list_parser
// Parses a configured number of whitespace-separated decimal fields.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one character per transaction in in_tdata; a transaction
//   with in_tlast set ends the text (its data byte is ignored).
//   Output stream: one result per transaction. out_tuser = 0 is a parsed
//   field, out_tuser = 1 the final status of the text, which also has
//   out_tlast set. A text ending inside a field yields two results.
//   A result is written into the result queue when the character that
//   closes it is taken. Throughput: one character per cycle, set by the
//   combinational multiply-by-ten and limit compare; in_tready drops only
//   while the four-entry result queue could not take two more results.
//   When the receiver stalls, results wait in the queue and input is held
//   off once the queue holds more than two results. Reset: field_count = 1,
//   32-bit mode, leading zeros allowed; the parser starts before the first
//   field of a new text and the queue is empty. The user writes configuration
//   (cfg_we, cfg_index, cfg_wdata) between texts; it is not enforced.
// ----------------------------------------------------------------------------
module decimal_field_list_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  // character stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] text_byte
  input  wire logic        in_tlast,   // end_of_text
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,  // [7:0] field_number, [71:8] field_value,
                                       // [74:72] parse_status, [79:75] zero
  output logic             out_tuser,  // item_kind
  output logic             out_tlast   // last_item
);
  import dflp_pkg::*;

  cfg_t    cfg_r;
  push_t   push;
  result_t head;
  logic    head_valid;
  logic    room;
  logic    in_accept;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.field_count          <= 8'd1;
      cfg_r.wide_mode            <= 1'b0;
      cfg_r.require_nonzero_lead <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIELD_COUNT:  cfg_r.field_count          <= cfg_wdata;
        CFG_WIDE_MODE:    cfg_r.wide_mode            <= cfg_wdata[0];
        CFG_NONZERO_LEAD: cfg_r.require_nonzero_lead <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_tready = room;
  assign in_accept = in_tvalid && in_tready;

  dflp_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .accept      (in_accept),
    .text_byte   (in_tdata),
    .end_of_text (in_tlast),
    .push        (push)
  );

  dflp_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .head       (head),
    .head_valid (head_valid),
    .pop        (out_tready),
    .room       (room)
  );

  // Drive the result stream from the queue head
  assign out_tvalid = head_valid;
  assign out_tdata  = {5'd0, head.parse_status, head.field_value, head.field_number};
  assign out_tuser  = head.item_kind;
  assign out_tlast  = head.last_item;

  // No result without an accepted character
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    !in_accept |-> !push.v0 && !push.v1)
    else $error("result pushed without an accepted character");

  // Second result only follows a first one and is always the status
  a_second_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    push.v1 |-> push.v0 && push.r1.last_item && push.r0.item_kind == KIND_FIELD)
    else $error("bad pair of results");

  // End of text always yields a final status
  a_end_status: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_tlast |-> push.v0 &&
      (push.v1 ? push.r1.item_kind == KIND_STATUS : push.r0.item_kind == KIND_STATUS))
    else $error("end of text without a status item");

  // Field items never close the text
  a_field_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_FIELD |-> !out_tlast)
    else $error("field item marked last");

endmodule
`default_nettype wire

// ===== hw/rtl/dflp_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dflp_parser
// Per-character parse step: phase, accumulator, field count and first error.
// ----------------------------------------------------------------------------
module dflp_parser (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire dflp_pkg::cfg_t  cfg,
  input  wire logic            accept,
  input  wire logic [7:0]      text_byte,
  input  wire logic            end_of_text,
  output dflp_pkg::push_t      push
);
  import dflp_pkg::*;

  typedef enum logic [3:0] {
    PH_GAP    = 4'b0001,
    PH_DIGITS = 4'b0010,
    PH_TAIL   = 4'b0100,
    PH_ERROR  = 4'b1000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [7:0]  done_r, done_nxt;
  status_t     err_r, err_nxt;

  logic [7:0]  done_inc;
  logic [3:0]  digit;
  logic [63:0] acc_times10;
  phase_t      ph;
  status_t     err;
  status_t     fin;
  result_t     fld_res;
  result_t     st_res;
  logic        emit_fld;

  assign done_inc    = done_r + 8'd1;
  assign digit       = 4'(text_byte - CHAR_ZERO);
  assign acc_times10 = {acc_r[60:0], 3'b000} + {acc_r[62:0], 1'b0};

  // Compute one step of the parser
  always_comb begin
    ph        = phase_r;
    err       = err_r;
    fin       = err_r;
    emit_fld  = 1'b0;
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    done_nxt  = done_r;
    err_nxt   = err_r;

    if (phase_r != PH_ERROR && cfg.field_count == 8'd0) begin
      ph  = PH_ERROR;
      err = ST_ZERO_COUNT;
    end
    if (ph == PH_GAP && done_r >= cfg.field_count) begin
      ph = PH_TAIL;
    end
    fin = err;

    if (end_of_text) begin
      unique case (ph)
        PH_DIGITS: begin
          emit_fld = 1'b1;
          fin      = (done_inc >= cfg.field_count) ? ST_OK : ST_TOO_FEW;
        end
        PH_GAP:   fin = ST_TOO_FEW;
        PH_TAIL:  fin = ST_OK;
        PH_ERROR: fin = err;
        default:  fin = err;
      endcase
      phase_nxt = PH_GAP;
      acc_nxt   = '0;
      done_nxt  = '0;
      err_nxt   = ST_OK;
    end else begin
      phase_nxt = ph;
      err_nxt   = err;
      unique case (ph)
        PH_GAP: begin
          if (!is_space(text_byte)) begin
            if (!is_digit(text_byte) ||
                (cfg.require_nonzero_lead && text_byte == CHAR_ZERO)) begin
              phase_nxt = PH_ERROR;
              err_nxt   = ST_BAD_CHAR;
            end else begin
              acc_nxt   = {60'd0, digit};
              phase_nxt = PH_DIGITS;
            end
          end
        end
        PH_DIGITS: begin
          if (is_digit(text_byte)) begin
            if (acc_r > digit_limit(cfg.wide_mode, digit)) begin
              phase_nxt = PH_ERROR;
              err_nxt   = ST_OVERFLOW;
            end else begin
              acc_nxt = acc_times10 + {60'd0, digit};
            end
          end else if (is_space(text_byte)) begin
            emit_fld  = 1'b1;
            done_nxt  = done_inc;
            acc_nxt   = '0;
            phase_nxt = (done_inc >= cfg.field_count) ? PH_TAIL : PH_GAP;
          end else begin
            phase_nxt = PH_ERROR;
            err_nxt   = ST_BAD_CHAR;
          end
        end
        PH_TAIL: begin
          if (!is_space(text_byte)) begin
            phase_nxt = PH_ERROR;
            err_nxt   = ST_TRAILING;
          end
        end
        PH_ERROR: phase_nxt = PH_ERROR;
        default:  phase_nxt = PH_ERROR;
      endcase
    end
  end

  // Build result items
  always_comb begin
    fld_res.item_kind    = KIND_FIELD;
    fld_res.field_number = done_r;
    fld_res.field_value  = acc_r;
    fld_res.parse_status = ST_OK;
    fld_res.last_item    = 1'b0;

    st_res.item_kind    = KIND_STATUS;
    st_res.field_number = '0;
    st_res.field_value  = '0;
    st_res.parse_status = fin;
    st_res.last_item    = 1'b1;

    push.v0 = accept && (emit_fld || end_of_text);
    push.v1 = accept && emit_fld && end_of_text;
    push.r0 = emit_fld ? fld_res : st_res;
    push.r1 = st_res;
  end

  // Advance state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_GAP;
      acc_r   <= '0;
      done_r  <= '0;
      err_r   <= ST_OK;
    end else if (accept) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      done_r  <= done_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/dflp_out_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dflp_out_queue
// Small result queue: takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
module dflp_out_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dflp_pkg::push_t   push,
  output dflp_pkg::result_t      head,
  output logic                   head_valid,
  input  wire logic              pop,
  output logic                   room
);
  import dflp_pkg::*;

  localparam logic [QAW:0] FULL_FOR_TWO = (QAW+1)'(QDEPTH - 2);

  result_t          mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     count_r, count_nxt;
  logic [QAW:0]     n_push;
  logic             do_pop;

  assign head_valid = (count_r != '0);
  assign head       = mem[rd_ptr_r];
  assign do_pop     = pop && head_valid;
  assign room       = (count_r <= FULL_FOR_TWO);
  assign n_push     = (QAW+1)'(push.v0) + (QAW+1)'(push.v1);

  assign wr_ptr_nxt = wr_ptr_r + QAW'(n_push);
  assign rd_ptr_nxt = rd_ptr_r + QAW'(do_pop);
  assign count_nxt  = count_r + n_push - (QAW+1)'(do_pop);

  // Store results
  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (push.v1) begin
      mem[wr_ptr_r + QAW'(1)] <= push.r1;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire
